/* sv/thfd_pkg.sv */
// Shared types, constants and CRC helper for the temperature/humidity frame decoder.
`default_nettype none
package thfd_pkg;

  localparam int FRAME_W    = 48;
  localparam int WORD_W     = 16;
  localparam int GAIN_W     = 17;
  localparam int OFFSET_W   = 15;
  localparam int TEMP_W     = 16;
  localparam int HUM_W      = 14;
  localparam int CFG_DATA_W = 17;
  localparam int CFG_IDX_W  = 1;

  localparam logic [GAIN_W-1:0]          GAIN_RESET   = 17'd66978;
  localparam logic signed [OFFSET_W-1:0] OFFSET_RESET = -15'sd408;

  localparam logic [CFG_IDX_W-1:0] REG_CAL_GAIN   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_CAL_OFFSET = 1'b1;

  localparam logic [7:0] CRC_POLY = 8'h31;
  localparam logic [7:0] CRC_INIT = 8'hFF;

  localparam logic [14:0] T_SCALE  = 15'd17500;
  localparam logic [13:0] H_SCALE  = 14'd12500;
  localparam logic [16:0] DIV_CONST = 17'd65535;
  localparam logic signed [15:0] T_BASE = 16'sd4500;
  localparam logic [13:0] H_BASE   = 14'd600;
  localparam logic [13:0] H_MAX    = 14'd10000;

  localparam int QUEUE_DEPTH_DEFAULT = 2;

  typedef struct packed {
    logic [WORD_W-1:0] t_word;
    logic [WORD_W-1:0] h_word;
    logic              t_ok;
    logic              h_ok;
  } frame_info_t;

  // One byte of CRC-8, MSB first.
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in, input logic [7:0] data);
    logic [7:0] c;
    c = crc_in ^ data;
    for (int b = 0; b < 8; b++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage
`default_nettype wire

/* sv/thfd_front.sv */
// Front end: accepts a frame and checks both word CRCs, one byte per cycle while the queue is not full.
`default_nettype none
module thfd_front
  import thfd_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [FRAME_W-1:0] response_frame,
  output logic                    push,
  output frame_info_t             push_data,
  input  wire logic               q_full
);

  typedef enum logic {F_IDLE, F_BYTE1} fstate_t;

  fstate_t              state;
  logic [FRAME_W-1:0]   frame;
  logic [7:0]           crc_t;
  logic [7:0]           crc_h;
  logic [7:0]           crc_t_fin;
  logic [7:0]           crc_h_fin;

  assign in_stall = (state != F_IDLE);

  always_comb begin
    crc_t_fin        = crc8_byte(crc_t, frame[39:32]);
    crc_h_fin        = crc8_byte(crc_h, frame[15:8]);
    push_data.t_word = frame[47:32];
    push_data.h_word = frame[23:8];
    push_data.t_ok   = (crc_t_fin == frame[31:24]);
    push_data.h_ok   = (crc_h_fin == frame[7:0]);
    push             = (state == F_BYTE1) && !q_full;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      case (state)
        F_IDLE: begin
          if (in_valid) begin
            frame <= response_frame;
            crc_t <= crc8_byte(CRC_INIT, response_frame[47:40]);
            crc_h <= crc8_byte(CRC_INIT, response_frame[23:16]);
            state <= F_BYTE1;
          end
        end
        F_BYTE1: begin
          if (!q_full) begin
            state <= F_IDLE;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

/* sv/thfd_queue.sv */
// Small FIFO of checked frames between front end and conversion back end.
`default_nettype none
module thfd_queue
  import thfd_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  push,
  input  wire frame_info_t push_data,
  output logic       full,
  input  wire logic  pop,
  output logic       empty,
  output frame_info_t head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  frame_info_t      mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full  = (count == CNT_W'(DEPTH));
  assign empty = (count == '0);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop && !empty) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if ((push && !full) && !(pop && !empty)) begin
        count <= count + 1'b1;
      end else if (!(push && !full) && (pop && !empty)) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

/* sv/thfd_back.sv */
// Back end: scales, calibrates and clamps the words, keeps last good values, drives results.
`default_nettype none
module thfd_back
  import thfd_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_write,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  q_empty,
  input  wire frame_info_t           q_head,
  output logic                       pop,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic signed [TEMP_W-1:0]   temperature_centi,
  output logic [HUM_W-1:0]           humidity_centi,
  output logic                       temp_available,
  output logic                       temp_crc_ok,
  output logic                       hum_crc_ok,
  output logic                       status
);

  typedef enum logic [1:0] {B_IDLE, B_DIV, B_MUL, B_DONE} bstate_t;

  bstate_t                      state;
  logic [GAIN_W-1:0]            cal_gain;
  logic signed [OFFSET_W-1:0]   cal_offset;

  logic                         t_ok;
  logic                         h_ok;
  logic [30:0]                  prod_t;
  logic [29:0]                  prod_h;
  logic signed [15:0]           base_t;
  logic [HUM_W-1:0]             rh;
  logic signed [33:0]           prod_g;

  logic signed [TEMP_W-1:0]     last_temperature;
  logic [HUM_W-1:0]             last_humidity;
  logic                         temp_seen;

  logic [14:0]                  q0_t;
  logic [16:0]                  rsum_t;
  logic [14:0]                  qt;
  logic [13:0]                  q0_h;
  logic [16:0]                  rsum_h;
  logic [13:0]                  qh;
  logic signed [15:0]           base_next;
  logic [HUM_W-1:0]             rh_next;
  logic signed [17:0]           shifted;
  logic signed [18:0]           sum_t;
  logic signed [TEMP_W-1:0]     temp_sat;
  logic signed [TEMP_W-1:0]     temp_new;
  logic [HUM_W-1:0]             hum_new;
  logic                         load;

  // x/65535: split x = 65536*q0 + l, remainder q0 + l stays below 2*65535
  always_comb begin
    q0_t   = prod_t[30:16];
    rsum_t = {2'b00, q0_t} + {1'b0, prod_t[15:0]};
    qt     = q0_t + 15'(rsum_t >= DIV_CONST);
    q0_h   = prod_h[29:16];
    rsum_h = {3'b000, q0_h} + {1'b0, prod_h[15:0]};
    qh     = q0_h + 14'(rsum_h >= DIV_CONST);

    base_next = $signed({1'b0, qt}) - T_BASE;
    if (qh < H_BASE) begin
      rh_next = '0;
    end else if (qh - H_BASE > H_MAX) begin
      rh_next = H_MAX;
    end else begin
      rh_next = qh - H_BASE;
    end

    // arithmetic shift gives the floor
    shifted = prod_g[33:16];
    sum_t   = {shifted[17], shifted} + {{4{cal_offset[OFFSET_W-1]}}, cal_offset};
    if (sum_t > 19'sd32767) begin
      temp_sat = 16'sh7FFF;
    end else if (sum_t < -19'sd32768) begin
      temp_sat = 16'sh8000;
    end else begin
      temp_sat = sum_t[15:0];
    end

    temp_new = t_ok ? temp_sat : last_temperature;
    hum_new  = h_ok ? rh : last_humidity;
    pop      = (state == B_IDLE) && !q_empty;
    load     = (state == B_DONE) && (!out_valid || !out_stall);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cal_gain   <= GAIN_RESET;
      cal_offset <= OFFSET_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_CAL_GAIN:   cal_gain   <= cfg_data;
        REG_CAL_OFFSET: cal_offset <= cfg_data[OFFSET_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= B_IDLE;
      out_valid        <= 1'b0;
      last_temperature <= '0;
      last_humidity    <= '0;
      temp_seen        <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        B_IDLE: begin
          if (!q_empty) begin
            t_ok   <= q_head.t_ok;
            h_ok   <= q_head.h_ok;
            prod_t <= 31'(T_SCALE) * 31'(q_head.t_word);
            prod_h <= 30'(H_SCALE) * 30'(q_head.h_word);
            state  <= B_DIV;
          end
        end
        B_DIV: begin
          base_t <= base_next;
          rh     <= rh_next;
          state  <= B_MUL;
        end
        B_MUL: begin
          prod_g <= base_t * $signed({1'b0, cal_gain});
          state  <= B_DONE;
        end
        B_DONE: begin
          if (load) begin
            last_temperature  <= temp_new;
            last_humidity     <= hum_new;
            temp_seen         <= temp_seen | t_ok;
            temperature_centi <= temp_new;
            humidity_centi    <= hum_new;
            temp_available    <= temp_seen | t_ok;
            temp_crc_ok       <= t_ok;
            hum_crc_ok        <= h_ok;
            status            <= !(t_ok && h_ok);
            out_valid         <= 1'b1;
            state             <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

/* sv/temp_humidity_frame_decoder_top.sv */
// The back end's four-step sequencer (scale multiply, divide by 65535, gain multiply,
// offset and saturate) finishes each frame before it pops the next, and out_stall can hold it.
// The front end checks one CRC byte per cycle while the queue is not full and runs
// ahead through the queue. Reset clears stored readings, the sticky flag and the queue,
// and loads cal_gain 66978 and cal_offset -408.
`default_nettype none
module temp_humidity_frame_decoder_top
  import thfd_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_write,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [FRAME_W-1:0]    response_frame,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic signed [TEMP_W-1:0]   temperature_centi,
  output logic [HUM_W-1:0]           humidity_centi,
  output logic                       temp_available,
  output logic                       temp_crc_ok,
  output logic                       hum_crc_ok,
  output logic                       status
);

  logic        push;
  frame_info_t push_data;
  logic        q_full;
  logic        q_empty;
  logic        pop;
  frame_info_t q_head;

  thfd_front u_front (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .response_frame (response_frame),
    .push           (push),
    .push_data      (push_data),
    .q_full         (q_full)
  );

  thfd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .empty     (q_empty),
    .head      (q_head)
  );

  thfd_back u_back (
    .clk               (clk),
    .rst               (rst),
    .cfg_write         (cfg_write),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .q_empty           (q_empty),
    .q_head            (q_head),
    .pop               (pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .temperature_centi (temperature_centi),
    .humidity_centi    (humidity_centi),
    .temp_available    (temp_available),
    .temp_crc_ok       (temp_crc_ok),
    .hum_crc_ok        (hum_crc_ok),
    .status            (status)
  );

endmodule
`default_nettype wire
